### design/assert_macros.svh
// assertion macros used by the task sleep timeout table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### design/tstt_pkg.sv
// types, codes and defaults for the task sleep timeout table
`timescale 1ns / 1ps

package tstt_pkg;

    localparam int DEF_PRIORITY_LEVELS = 4;
    localparam int DEF_TASKS_PER_LEVEL = 8;

    localparam int STATE_W  = 3;
    localparam int SLEEP_W  = 32;
    localparam int UPTIME_W = 32;
    localparam int WOKEN_W  = 6;
    localparam int ACTION_W = 2;

    localparam logic [WOKEN_W-1:0] WOKEN_MAX = {WOKEN_W{1'b1}};

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

    // task state codes, other codes are stored and left alone by ticks unless the entry is forced ready
    localparam logic [STATE_W-1:0] TS_READY        = 3'd0;
    localparam logic [STATE_W-1:0] TS_WAITING      = 3'd1;
    localparam logic [STATE_W-1:0] TS_BLOCKED_GIVE = 3'd2;
    localparam logic [STATE_W-1:0] TS_BLOCKED_TAKE = 3'd3;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [SLEEP_W-1:0] sleep;
        logic               timeout_enable;
        logic               answer;
    } entry_t;

    typedef struct packed {
        entry_t entry;
        logic   force_ready;
    } scan_req_t;

    typedef struct packed {
        entry_t entry;
        logic   woke;
    } scan_res_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

endpackage

### design/tstt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/tstt_scan_unit.sv
// per-entry decrement and timeout unit shared by the whole tick walk
`timescale 1ns / 1ps

module tstt_scan_unit (
    input  tstt_pkg::scan_req_t req,
    output tstt_pkg::scan_res_t res
);

    logic [tstt_pkg::STATE_W-1:0] cur_state;
    logic                         timed;

    always_comb begin
        // interrupted task is made ready ahead of the timeout check
        cur_state = req.force_ready ? tstt_pkg::TS_READY : req.entry.state;

        case (cur_state) inside
            tstt_pkg::TS_WAITING: begin
                timed = 1'b1;
            end
            tstt_pkg::TS_BLOCKED_GIVE, tstt_pkg::TS_BLOCKED_TAKE: begin
                timed = req.entry.timeout_enable;
            end
            default: begin
                timed = 1'b0;
            end
        endcase

        res.entry       = req.entry;
        res.entry.state = cur_state;
        res.woke        = 1'b0;

        if (timed) begin
            if (req.entry.sleep != '0) begin
                res.entry.sleep = req.entry.sleep - 1'b1;
            end else begin
                res.entry.state = tstt_pkg::TS_READY;
                res.woke        = 1'b1;
                // a blocked task that times out loses its answer
                if (cur_state != tstt_pkg::TS_WAITING) begin
                    res.entry.answer = 1'b0;
                end
            end
        end
    end

endmodule

### design/task_sleep_timeout_table.sv
// task sleep timeout table: tick service over a priority by slot task table
`timescale 1ns / 1ps
// tick: the result waits for the walk that reads and writes back one table entry
//   per cycle through the ram
// read, write and unused actions go through the done state to the output register; no new
//   transaction is taken until the result enters the output register, which waits while m_ready is low
// reset: synchronous active low; afterwards a clearing pass zeroes the table,
//   one entry per cycle with s_ready low

`include "assert_macros.svh"

module task_sleep_timeout_table #(
    parameter int PRIORITY_LEVELS = tstt_pkg::DEF_PRIORITY_LEVELS,
    parameter int TASKS_PER_LEVEL = tstt_pkg::DEF_TASKS_PER_LEVEL
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input transaction
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [1:0]  s_prior_index,
    input  logic [2:0]  s_task_index,
    input  logic [2:0]  s_new_state,
    input  logic [31:0] s_new_sleep,
    input  logic        s_new_timeout_enable,
    input  logic        s_new_answer,

    // result transaction
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_uptime_ticks,
    output logic [5:0]  m_woken_count,
    output logic [2:0]  m_read_state,
    output logic [31:0] m_read_sleep,
    output logic        m_read_timeout_enable,
    output logic        m_read_answer
);

    localparam int ENTRIES = PRIORITY_LEVELS * TASKS_PER_LEVEL;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ENTRY_W = $bits(tstt_pkg::entry_t);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

    // sequencer state
    tstt_pkg::seq_state_t state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;          // clear and walk counter
    logic                 wb_valid_reg, wb_valid_next; // ram read data awaits write back
    logic [ADDR_W-1:0]    wb_addr_reg, wb_addr_next;

    // item context
    logic [tstt_pkg::ACTION_W-1:0] act_reg, act_next;
    logic                          addr_ok_reg, addr_ok_next;
    logic [ADDR_W-1:0]             mark_addr_reg, mark_addr_next;

    // architectural counters
    logic [tstt_pkg::UPTIME_W-1:0] uptime_reg, uptime_next;
    logic [tstt_pkg::WOKEN_W-1:0]  woken_reg, woken_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [tstt_pkg::UPTIME_W-1:0] m_uptime_reg, m_uptime_next;
    logic [tstt_pkg::WOKEN_W-1:0]  m_woken_reg, m_woken_next;
    tstt_pkg::entry_t              m_entry_reg, m_entry_next;

    // ram ports
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    tstt_pkg::entry_t   rd_entry;

    tstt_pkg::scan_req_t scan_req;
    tstt_pkg::scan_res_t scan_res;
    tstt_pkg::entry_t    wr_entry;

    logic              s_accept;
    logic              out_free;
    logic              s_addr_ok;
    logic [ADDR_W-1:0] s_slot;

    assign s_ready  = (state_reg == tstt_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // entry address from level and slot; out of range leaves the table alone
    assign s_addr_ok = (int'(s_prior_index) < PRIORITY_LEVELS) &&
                       (int'(s_task_index) < TASKS_PER_LEVEL);
    assign s_slot    = ADDR_W'(int'(s_prior_index) * TASKS_PER_LEVEL + int'(s_task_index));

    assign rd_entry = tstt_pkg::entry_t'(ram_rd_data);

    // entry loaded by a write transaction
    always_comb begin
        wr_entry.state          = s_new_state;
        wr_entry.sleep          = s_new_sleep;
        wr_entry.timeout_enable = s_new_timeout_enable;
        wr_entry.answer         = s_new_answer;
    end

    // walk update: the interrupted task is forced ready as it passes
    assign scan_req.entry       = rd_entry;
    assign scan_req.force_ready = addr_ok_reg && (wb_addr_reg == mark_addr_reg);

    tstt_scan_unit u_scan (
        .req (scan_req),
        .res (scan_res)
    );

    tstt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tstt_pkg::ST_CLEAR;
            idx_reg      <= '0;
            wb_valid_reg <= 1'b0;
            uptime_reg   <= '0;
            woken_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            wb_valid_reg <= wb_valid_next;
            uptime_reg   <= uptime_next;
            woken_reg    <= woken_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        wb_addr_reg   <= wb_addr_next;
        act_reg       <= act_next;
        addr_ok_reg   <= addr_ok_next;
        mark_addr_reg <= mark_addr_next;
        m_uptime_reg  <= m_uptime_next;
        m_woken_reg   <= m_woken_next;
        m_entry_reg   <= m_entry_next;
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = idx_reg[ADDR_W-1:0];
        act_next       = act_reg;
        addr_ok_next   = addr_ok_reg;
        mark_addr_next = mark_addr_reg;
        uptime_next    = uptime_reg;
        woken_next     = woken_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_uptime_next  = m_uptime_reg;
        m_woken_next   = m_woken_reg;
        m_entry_next   = m_entry_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg[ADDR_W-1:0];
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = s_slot;

        unique case (state_reg)
            // zero one entry per cycle after reset
            tstt_pkg::ST_CLEAR: begin
                ram_wr_en = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == CNT_LAST) begin
                    idx_next   = '0;
                    state_next = tstt_pkg::ST_IDLE;
                end
            end

            tstt_pkg::ST_IDLE: begin
                if (s_accept) begin
                    act_next       = s_action;
                    addr_ok_next   = s_addr_ok;
                    mark_addr_next = s_slot;
                    woken_next     = '0;
                    state_next     = tstt_pkg::ST_DONE;
                    unique case (s_action)
                        tstt_pkg::ACT_TICK: begin
                            uptime_next = uptime_reg + 1'b1;
                            idx_next    = '0;
                            state_next  = tstt_pkg::ST_SCAN;
                        end
                        tstt_pkg::ACT_WRITE: begin
                            ram_wr_en   = s_addr_ok;
                            ram_wr_addr = s_slot;
                            ram_wr_data = wr_entry;
                        end
                        tstt_pkg::ACT_READ: begin
                            ram_rd_en = 1'b1;
                        end
                        default: begin
                            // unused action: result only
                        end
                    endcase
                end
            end

            // read entry k while writing back entry k-1
            tstt_pkg::ST_SCAN: begin
                if (idx_reg != CNT_END) begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                    wb_valid_next = 1'b1;
                    wb_addr_next  = idx_reg[ADDR_W-1:0];
                end else begin
                    state_next = tstt_pkg::ST_DONE;
                end
                if (wb_valid_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = wb_addr_reg;
                    ram_wr_data = scan_res.entry;
                    if (scan_res.woke && (woken_reg != tstt_pkg::WOKEN_MAX)) begin
                        woken_next = woken_reg + 1'b1;
                    end
                end
            end

            // hand the result to the output register once it is free
            tstt_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_uptime_next = uptime_reg;
                    m_woken_next  = (act_reg == tstt_pkg::ACT_TICK) ? woken_reg : '0;
                    if ((act_reg == tstt_pkg::ACT_READ) && addr_ok_reg) begin
                        m_entry_next = rd_entry;
                    end else begin
                        m_entry_next = '0;
                    end
                    state_next = tstt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tstt_pkg::ST_CLEAR;
            end
        endcase
    end

    assign m_valid               = m_valid_reg;
    assign m_uptime_ticks        = m_uptime_reg;
    assign m_woken_count         = m_woken_reg;
    assign m_read_state          = m_entry_reg.state;
    assign m_read_sleep          = m_entry_reg.sleep;
    assign m_read_timeout_enable = m_entry_reg.timeout_enable;
    assign m_read_answer         = m_entry_reg.answer;

    // only a tick transaction counts woken entries
    `ASSERT_NEVER(a_woken_tick_only, aclk, aresetn, (state_reg == tstt_pkg::ST_DONE) && (act_reg != tstt_pkg::ACT_TICK) && (woken_reg != '0))
    // write back trails the walk read by exactly one entry
    `ASSERT_PROP(a_wb_trails_read, aclk, aresetn, wb_valid_reg |-> ((CNT_W'(wb_addr_reg) + 1'b1) == idx_reg))
    // uptime moves only when a tick transaction is taken
    `ASSERT_PROP(a_uptime_on_tick, aclk, aresetn, !(s_accept && (s_action == tstt_pkg::ACT_TICK)) |=> $stable(uptime_reg))

endmodule
